/* rtl/core/sdau_pkg.sv */
// ----------------------------------------------------------------------------
// sdau_pkg: shared types and constants of the scaled decimal arithmetic unit
// Operation, rounding and status codes, the power-of-ten table and the
// command/response structs of the shared shift-add/subtract unit.
// ----------------------------------------------------------------------------
package sdau_pkg;

    localparam int MANT_W          = 128;
    localparam int WIDE_W          = 256;
    localparam int SCALE_W         = 5;
    localparam int POW_IDX_W       = 6;
    localparam int POW_LAST        = 38;
    localparam int SCALE_LIMIT_DEF = 18;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_ADD = 3'd0;
    localparam mode_t MODE_SUB = 3'd1;
    localparam mode_t MODE_MUL = 3'd2;
    localparam mode_t MODE_DIV = 3'd3;
    localparam mode_t MODE_RND = 3'd4;
    localparam mode_t MODE_CMP = 3'd5;

    typedef logic [2:0] rmode_t;
    localparam rmode_t RM_HALF_UP   = 3'd0;
    localparam rmode_t RM_HALF_EVEN = 3'd1;
    localparam rmode_t RM_DOWN      = 3'd2;
    localparam rmode_t RM_UP        = 3'd3;
    localparam rmode_t RM_CEIL      = 3'd4;
    localparam rmode_t RM_FLOOR     = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_INVALID  = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;
    localparam status_t ST_DIVZERO  = 2'd3;

    typedef logic [(1 << POW_IDX_W) - 1:0][MANT_W-1:0] pow_tab_t;

    function automatic pow_tab_t gen_pow10();
        pow_tab_t          t;
        logic [MANT_W-1:0] v;
        t = '0;
        v = MANT_W'(1);
        for (int i = 0; i < (1 << POW_IDX_W); i++)
        begin
            if (i <= POW_LAST)
            begin
                t[i] = v;
            end
            v = v * MANT_W'(10);
        end
        return t;
    endfunction

    localparam pow_tab_t POW10_TAB = gen_pow10();

    function automatic logic [MANT_W-1:0] pow10(input logic [POW_IDX_W-1:0] idx);
        return POW10_TAB[idx];
    endfunction

    typedef struct packed {
        logic              go;
        logic              is_div;
        logic [WIDE_W-1:0] x;
        logic [WIDE_W-1:0] y;
    } unit_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WIDE_W-1:0] acc;
        logic [WIDE_W-1:0] aux;
        logic [WIDE_W-1:0] den;
    } unit_rsp_t;

endpackage

/* rtl/core/sdau_if.sv */
// ----------------------------------------------------------------------------
// sdau_if: request and response channels of the scaled decimal unit
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sdau_req_if;
    import sdau_pkg::*;
    logic                valid;
    logic                ready;
    mode_t               mode;
    logic signed [63:0]  a_mant_hi;
    logic [63:0]         a_mant_lo;
    logic [4:0]          a_scale;
    logic signed [63:0]  b_mant_hi;
    logic [63:0]         b_mant_lo;
    logic [4:0]          b_scale;
    logic [4:0]          dst_scale;
    rmode_t              rounding;

    modport source (output valid, mode, a_mant_hi, a_mant_lo, a_scale, b_mant_hi,
                    b_mant_lo, b_scale, dst_scale, rounding, input ready);
    modport sink   (input valid, mode, a_mant_hi, a_mant_lo, a_scale, b_mant_hi,
                    b_mant_lo, b_scale, dst_scale, rounding, output ready);
endinterface

interface sdau_rsp_if;
    import sdau_pkg::*;
    logic                valid;
    logic                ready;
    logic signed [63:0]  res_mant_hi;
    logic [63:0]         res_mant_lo;
    logic [4:0]          res_scale;
    status_t             status;
    logic signed [1:0]   order;

    modport source (output valid, res_mant_hi, res_mant_lo, res_scale, status, order,
                    input ready);
    modport sink   (input valid, res_mant_hi, res_mant_lo, res_scale, status, order,
                    output ready);
endinterface

/* rtl/core/scaled_decimal_arith_unit.sv */
// ----------------------------------------------------------------------------
// scaled_decimal_arith_unit: 128-bit scaled decimal add/sub/mul/div/round/cmp
// Sequencer around one shared shift-add / restoring-divide unit.
// ----------------------------------------------------------------------------
// Steps: errors and zero shortcuts skip the shared unit; add, subtract and compare
// run two multiplies, multiply one multiply and a divide on scale overflow, divide
// a multiply and a divide, round a multiply or, when the scale falls, a divide.
// Throughput: one item at a time; req.ready is high only while idle, and the unit
// returns to idle in the cycle after the result beat.
// Reset: asynchronous, active low; clears the sequencer and the result valid.
module scaled_decimal_arith_unit #(
    parameter int SCALE_LIMIT = sdau_pkg::SCALE_LIMIT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sdau_req_if.sink  req,
    sdau_rsp_if.source rsp
);
    import sdau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SETUP = 8'b0000_0010,
        S_MULA  = 8'b0000_0100,
        S_MULB  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_RND   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    localparam logic [SCALE_W-1:0]   MAX_S  = SCALE_W'(SCALE_LIMIT);
    localparam logic [SCALE_W:0]     MAX_S6 = (SCALE_W+1)'(SCALE_LIMIT);

    state_t state_reg, state_next;

    unit_cmd_t ucmd;
    unit_rsp_t urs;

    mode_t               mode_reg;
    logic [MANT_W-1:0]   ma_reg, mb_reg;
    logic                na_reg, nb_reg;
    logic [SCALE_W-1:0]  as_reg, bs_reg, ts_reg;
    rmode_t              rm_reg;
    logic [WIDE_W-1:0]   p1_reg, p2_reg;

    logic [MANT_W-1:0]   mant_reg;
    logic [SCALE_W-1:0]  scale_reg;
    status_t             status_reg;
    logic [1:0]          order_reg;
    logic                out_valid_reg;

    logic [MANT_W-1:0]   a_in, b_in;

    // decode of the captured item
    logic                is_addsub, is_mul, is_div, is_rnd, is_cmp;
    logic                az, bz, rnd_down, sh_neg;
    logic [SCALE_W-1:0]  ms;
    logic [SCALE_W:0]    ssum;
    logic [SCALE_W+1:0]  sh;
    logic [POW_IDX_W-1:0] sh_abs;
    status_t             chk_st;
    logic                early_zero, ok_go, need_mul_a, need_mul_b, need_div;
    logic [SCALE_W-1:0]  early_scale;
    logic                neg_res;

    unit_cmd_t           mul_a_cmd, mul_b_cmd, div_cmd;

    // rounding
    logic [WIDE_W:0]     rem2, den_x;
    logic                half_gt, half_eq, has_rem, rnd_up;
    rmode_t              rmode;

    // final
    logic [MANT_W-1:0]   fin_mant;
    logic [SCALE_W-1:0]  fin_scale;
    status_t             fin_status;
    logic [1:0]          fin_order;
    logic [MANT_W-1:0]   sa_m, sb_m;
    logic [MANT_W:0]     sa, sb, ssig;

    function automatic logic fits_signed(input logic [WIDE_W-1:0] m, input logic neg);
        return (m[WIDE_W-1:MANT_W] == '0) &&
               (!m[MANT_W-1] || (neg && (m[MANT_W-2:0] == '0)));
    endfunction

    function automatic logic [MANT_W-1:0] apply_sign(input logic [MANT_W-1:0] m,
                                                     input logic neg);
        return neg ? (~m + MANT_W'(1)) : m;
    endfunction

    assign a_in = {req.a_mant_hi, req.a_mant_lo};
    assign b_in = {req.b_mant_hi, req.b_mant_lo};

    always_comb
    begin
        is_addsub = (mode_reg == MODE_ADD) || (mode_reg == MODE_SUB);
        is_mul    = (mode_reg == MODE_MUL);
        is_div    = (mode_reg == MODE_DIV);
        is_rnd    = (mode_reg == MODE_RND);
        is_cmp    = (mode_reg == MODE_CMP);
        az        = (ma_reg == '0);
        bz        = (mb_reg == '0);
        ms        = (as_reg > bs_reg) ? as_reg : bs_reg;
        ssum      = {1'b0, as_reg} + {1'b0, bs_reg};
        sh        = {2'b00, ts_reg} + {2'b00, bs_reg} - {2'b00, as_reg};
        sh_neg    = sh[SCALE_W+1];
        sh_abs    = sh_neg ? POW_IDX_W'(-sh) : sh[POW_IDX_W-1:0];
        rnd_down  = as_reg > ts_reg;
        neg_res   = is_rnd ? na_reg : (na_reg ^ nb_reg);

        chk_st = ST_OK;
        priority if (is_addsub || is_mul)
        begin
            if (as_reg > MAX_S || bs_reg > MAX_S)
                chk_st = ST_INVALID;
        end
        else if (is_div)
        begin
            if (bz)
                chk_st = ST_DIVZERO;
            else if (ts_reg > MAX_S || rm_reg > RM_FLOOR || as_reg > MAX_S ||
                     bs_reg > MAX_S)
                chk_st = ST_INVALID;
        end
        else if (is_rnd)
        begin
            if (ts_reg > MAX_S || rm_reg > RM_FLOOR || as_reg > MAX_S)
                chk_st = ST_INVALID;
        end
        else if (is_cmp)
        begin
            chk_st = ST_OK;
        end
        else
        begin
            chk_st = ST_INVALID;
        end

        early_zero  = (is_mul && (az || bz)) || ((is_div || is_rnd) && az);
        early_scale = is_mul ? ((ssum > MAX_S6) ? MAX_S : ssum[SCALE_W-1:0]) : ts_reg;
        ok_go       = (chk_st == ST_OK) && !early_zero;
        need_mul_a  = ok_go && !(is_rnd && rnd_down);
        need_mul_b  = ok_go && (is_addsub || is_cmp);
        need_div    = ok_go && ((is_mul && ssum > MAX_S6) || is_div || (is_rnd && rnd_down));
    end

    // operand selection for the shared unit
    always_comb
    begin
        mul_a_cmd        = '0;
        mul_a_cmd.go     = 1'b1;
        mul_a_cmd.x      = {{MANT_W{1'b0}}, (is_div && sh_neg) ? mb_reg : ma_reg};
        priority if (is_addsub || is_cmp)
            mul_a_cmd.y = {{MANT_W{1'b0}}, pow10(POW_IDX_W'(ms - as_reg))};
        else if (is_mul)
            mul_a_cmd.y = {{MANT_W{1'b0}}, mb_reg};
        else if (is_div)
            mul_a_cmd.y = {{MANT_W{1'b0}}, pow10(sh_abs)};
        else
            mul_a_cmd.y = {{MANT_W{1'b0}}, pow10(POW_IDX_W'(ts_reg - as_reg))};

        mul_b_cmd    = '0;
        mul_b_cmd.go = 1'b1;
        mul_b_cmd.x  = {{MANT_W{1'b0}}, mb_reg};
        mul_b_cmd.y  = {{MANT_W{1'b0}}, pow10(POW_IDX_W'(ms - bs_reg))};

        div_cmd        = '0;
        div_cmd.go     = 1'b1;
        div_cmd.is_div = 1'b1;
        // the product of the first multiply is still held in the unit
        div_cmd.x = (is_mul || (is_div && !sh_neg)) ? urs.acc : {{MANT_W{1'b0}}, ma_reg};
        priority if (is_mul)
            div_cmd.y = {{MANT_W{1'b0}}, pow10(POW_IDX_W'(ssum - MAX_S6))};
        else if (is_div)
            div_cmd.y = sh_neg ? urs.acc : {{MANT_W{1'b0}}, mb_reg};
        else
            div_cmd.y = {{MANT_W{1'b0}}, pow10(POW_IDX_W'(as_reg - ts_reg))};
    end

    always_comb
    begin
        state_next = state_reg;
        ucmd       = '0;
        unique case (state_reg)
            S_IDLE:
                if (req.valid)
                    state_next = S_SETUP;
            S_SETUP:
                if (need_mul_a)
                begin
                    ucmd       = mul_a_cmd;
                    state_next = S_MULA;
                end
                else if (need_div)
                begin
                    ucmd       = div_cmd;
                    state_next = S_DIV;
                end
                else
                    state_next = S_FIN;
            S_MULA:
                if (urs.done)
                begin
                    if (need_mul_b)
                    begin
                        ucmd       = mul_b_cmd;
                        state_next = S_MULB;
                    end
                    else if (need_div)
                    begin
                        ucmd       = div_cmd;
                        state_next = S_DIV;
                    end
                    else
                        state_next = S_FIN;
                end
            S_MULB:
                if (urs.done)
                    state_next = S_FIN;
            S_DIV:
                if (urs.done)
                    state_next = S_RND;
            S_RND:
                state_next = S_FIN;
            S_FIN:
                state_next = S_OUT;
            S_OUT:
                if (rsp.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // rounding of quotient from the shared unit
    always_comb
    begin
        rem2    = {urs.acc, 1'b0};
        den_x   = {1'b0, urs.den};
        half_gt = rem2 > den_x;
        half_eq = rem2 == den_x;
        has_rem = urs.acc != '0;
        rmode   = is_mul ? RM_HALF_UP : rm_reg;
        unique case (rmode)
            RM_HALF_UP:   rnd_up = half_gt || half_eq;
            RM_HALF_EVEN: rnd_up = half_gt || (half_eq && urs.aux[0]);
            RM_UP:        rnd_up = has_rem;
            RM_CEIL:      rnd_up = !neg_res && has_rem;
            RM_FLOOR:     rnd_up = neg_res && has_rem;
            default:      rnd_up = 1'b0;
        endcase
    end

    always_comb
    begin
        fin_mant   = '0;
        fin_scale  = '0;
        fin_status = ST_OK;
        fin_order  = 2'b00;
        sa_m = apply_sign(p1_reg[MANT_W-1:0], na_reg);
        sb_m = apply_sign(p2_reg[MANT_W-1:0], nb_reg);
        sa   = {sa_m[MANT_W-1], sa_m};
        sb   = {sb_m[MANT_W-1], sb_m};
        ssig = (mode_reg == MODE_SUB) ? (sa - sb) : (sa + sb);
        priority if (chk_st != ST_OK)
            fin_status = chk_st;
        else if (early_zero)
            fin_scale = early_scale;
        else if (is_addsub)
        begin
            if (!fits_signed(p1_reg, na_reg) || !fits_signed(p2_reg, nb_reg) ||
                (ssig[MANT_W] != ssig[MANT_W-1]))
                fin_status = ST_OVERFLOW;
            else
            begin
                fin_mant  = ssig[MANT_W-1:0];
                fin_scale = ms;
            end
        end
        else if (is_cmp)
        begin
            priority if (az && bz)
                fin_order = 2'b00;
            else if (az)
                fin_order = nb_reg ? 2'b01 : 2'b11;
            else if (bz || (na_reg != nb_reg))
                fin_order = na_reg ? 2'b11 : 2'b01;
            else if (p1_reg == p2_reg)
                fin_order = 2'b00;
            else
                fin_order = ((p1_reg > p2_reg) ^ na_reg) ? 2'b01 : 2'b11;
        end
        else
        begin
            if (fits_signed(p1_reg, neg_res))
            begin
                fin_mant  = apply_sign(p1_reg[MANT_W-1:0], neg_res);
                fin_scale = early_scale;
            end
            else
                fin_status = ST_OVERFLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            mode_reg <= req.mode;
            na_reg   <= a_in[MANT_W-1];
            nb_reg   <= b_in[MANT_W-1];
            ma_reg   <= apply_sign(a_in, a_in[MANT_W-1]);
            mb_reg   <= apply_sign(b_in, b_in[MANT_W-1]);
            as_reg   <= req.a_scale;
            bs_reg   <= req.b_scale;
            ts_reg   <= req.dst_scale;
            rm_reg   <= req.rounding;
        end
        if (state_reg == S_MULA && urs.done)
            p1_reg <= urs.acc;
        if (state_reg == S_MULB && urs.done)
            p2_reg <= urs.acc;
        if (state_reg == S_RND)
            p1_reg <= urs.aux + {{(WIDE_W-1){1'b0}}, rnd_up};
        if (state_reg == S_FIN)
        begin
            mant_reg   <= fin_mant;
            scale_reg  <= fin_scale;
            status_reg <= fin_status;
            order_reg  <= fin_order;
        end
    end

    sdau_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ucmd),
        .rsp   (urs)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.res_mant_hi = mant_reg[MANT_W-1:MANT_W/2];
    assign rsp.res_mant_lo = mant_reg[MANT_W/2-1:0];
    assign rsp.res_scale   = scale_reg;
    assign rsp.status      = status_reg;
    assign rsp.order       = order_reg;

    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !urs.busy)
        else $error("accepting while shared unit busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
            (rsp.res_mant_hi == '0 && rsp.res_mant_lo == '0 && rsp.res_scale == '0 &&
             rsp.order == '0))
        else $error("error result not cleared");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_SETUP))
        else $error("accepted beat not decoded");

    a_done_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
        urs.done |-> (state_reg == S_MULA || state_reg == S_MULB || state_reg == S_DIV))
        else $error("unit finished outside a compute step");

endmodule

/* rtl/core/sdau_iter_unit.sv */
// ----------------------------------------------------------------------------
// sdau_iter_unit: shared shift-add multiplier / restoring divider
// One 258-bit adder; multiply takes 128 steps, divide 256 steps.
// ----------------------------------------------------------------------------
module sdau_iter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdau_pkg::unit_cmd_t  cmd,
    output sdau_pkg::unit_rsp_t  rsp
);
    import sdau_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic              busy_reg;
    logic              done_reg;
    logic              div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_last;
    logic [WIDE_W-1:0] acc_reg;   // product or partial remainder
    logic [WIDE_W-1:0] wrk_reg;   // multiplicand or dividend
    logic [WIDE_W-1:0] aux_reg;   // multiplier or quotient
    logic [WIDE_W-1:0] den_reg;
    logic [WIDE_W-1:0] shifted;
    logic [WIDE_W+1:0] opa;
    logic [WIDE_W+1:0] opb;
    logic [WIDE_W+1:0] sum;
    logic              take;

    assign cnt_last = div_reg ? CNT_W'(WIDE_W - 1) : CNT_W'(MANT_W - 1);

    always_comb
    begin
        shifted = {acc_reg[WIDE_W-2:0], wrk_reg[WIDE_W-1]};
        if (div_reg)
        begin
            opa = {1'b0, acc_reg[WIDE_W-1], shifted};
            opb = ~{2'b00, den_reg};
        end
        else
        begin
            opa = {2'b00, acc_reg};
            opb = {2'b00, wrk_reg};
        end
        sum  = opa + opb + {{(WIDE_W+1){1'b0}}, div_reg};
        take = !sum[WIDE_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == cnt_last);
            if (cmd.go)
            begin
                busy_reg <= 1'b1;
                div_reg  <= cmd.is_div;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == cnt_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            acc_reg <= '0;
            wrk_reg <= cmd.x;
            aux_reg <= cmd.is_div ? '0 : cmd.y;
            den_reg <= cmd.y;
        end
        else if (busy_reg)
        begin
            wrk_reg <= {wrk_reg[WIDE_W-2:0], 1'b0};
            if (div_reg)
            begin
                acc_reg <= take ? sum[WIDE_W-1:0] : shifted;
                aux_reg <= {aux_reg[WIDE_W-2:0], take};
            end
            else
            begin
                if (aux_reg[0])
                begin
                    acc_reg <= sum[WIDE_W-1:0];
                end
                aux_reg <= {1'b0, aux_reg[WIDE_W-1:1]};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;
    assign rsp.aux  = aux_reg;
    assign rsp.den  = den_reg;

endmodule
